FILE: hdl/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
// No dependencies; every other file of the block but mme_ram refers to it by scoped names.
package mme_pkg;

    // Width of one dimension register.
    localparam int DIM_W = 4;
    // Width of the row and column fields on the ports.
    localparam int IDX_W = 3;
    // Width of a result sum, signed Q36.0 (integer); sums wrap modulo 2^SUM_W.
    localparam int SUM_W = 36;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Item operation codes.
    typedef enum logic [1:0] {
        MODE_WRITE_A = 2'd0,
        MODE_WRITE_B = 2'd1,
        MODE_COMPUTE = 2'd2
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_OF_A  = 2'd0,
        REG_INNER_SIZE = 2'd1,
        REG_COLS_OF_B  = 2'd2
    } t_cfg_reg;

    // Control that travels with each pair of store reads.
    typedef struct packed {
        logic             valid;     // a multiply-accumulate step is in flight
        logic             first;     // first step of a dot product
        logic             last_k;    // final step of a dot product
        logic             zero;      // inner size is zero: the term counts as nothing
        logic             last_elem; // final element of the product
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage

FILE: hdl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: configuration registers, operand stores.
// Depends on mme_pkg, mme_ram, mme_seq and mme_mac.
//
//  Channel    Signals                                          Direction  Beat taken when
//  ---------  -----------------------------------------------  ---------  -------------------
//  item       start, busy, i_mode, i_row_index, i_col_index,   in         start && !busy
//             i_element_value
//  result     o_result_valid, o_out_row, o_out_col,            out        o_result_valid
//             o_product_value, o_last_element
//  config     i_cfg_we, i_cfg_index, i_cfg_data                in         i_cfg_we
//
// A write item (mode 0 or 1) lands in its store at the edge that accepts it; busy never
// rises for it, so writes can stream at one beat per cycle while no product is running.
// A compute item issues n multiply-accumulate steps (one when n is zero) for each of the
// m * p results, one per cycle, set by the single read port of each operand store, through
// the pipeline of store read, multiply and accumulate; busy is high throughout, and the
// last result strobe comes in the same cycle that busy falls.
// Reset is synchronous and active low. It clears the control state and sets every
// dimension to 8; the operand stores are not cleared and must be written before use.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module matrix_multiply_engine #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item channel.
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_mode,
    input  logic [mme_pkg::IDX_W-1:0]         i_row_index,
    input  logic [mme_pkg::IDX_W-1:0]         i_col_index,
    input  logic signed [ELEM_WIDTH-1:0]      i_element_value,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]         i_cfg_data,
    // Result channel.
    output logic                              o_result_valid,
    output logic [mme_pkg::IDX_W-1:0]         o_out_row,
    output logic [mme_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [mme_pkg::SUM_W-1:0]  o_product_value,
    output logic                              o_last_element
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [mme_pkg::DIM_W-1:0] r_rows_of_a, r_inner_size, r_cols_of_b;

    logic          accept;
    logic          in_range;
    logic          we_a, we_b, go;
    logic [AW-1:0] waddr;
    logic [AW-1:0] a_raddr, b_raddr;
    logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;
    logic          seq_active, mac_busy;
    mme_pkg::t_tag tag;
    logic [mme_pkg::SUM_W-1:0] sum;

    // Dimension registers. Writes to an index beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_of_a  <= mme_pkg::DIM_W'(8);
            r_inner_size <= mme_pkg::DIM_W'(8);
            r_cols_of_b  <= mme_pkg::DIM_W'(8);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mme_pkg::REG_ROWS_OF_A:  r_rows_of_a  <= i_cfg_data;
                mme_pkg::REG_INNER_SIZE: r_inner_size <= i_cfg_data;
                mme_pkg::REG_COLS_OF_B:  r_cols_of_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // An item is taken whenever the block is not walking a product. Writes whose row or
    // column lies outside the store are dropped; that only arises when MAX_DIM is below 8.
    assign accept   = start && !busy;
    assign in_range = (int'(i_row_index) < MAX_DIM) && (int'(i_col_index) < MAX_DIM);
    assign waddr    = AW'(AW'(i_row_index) * AW'(MAX_DIM) + AW'(i_col_index));

    always_comb begin
        we_a = 1'b0;
        we_b = 1'b0;
        go   = 1'b0;
        if (accept) begin
            unique case (i_mode)
                mme_pkg::MODE_WRITE_A: we_a = in_range;
                mme_pkg::MODE_WRITE_B: we_b = in_range;
                mme_pkg::MODE_COMPUTE: go   = 1'b1;
                default: ;
            endcase
        end
    end

    // Writes and reads never overlap: a product walk only reads, and no write is
    // accepted while busy is high, so the stores need no forwarding.
    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_element_value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_element_value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // The sequencer issues one A read and one B read per cycle, row-major over the result
    // and the inner dimension innermost.
    mme_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_rows   (r_rows_of_a),
        .i_inner  (r_inner_size),
        .i_cols   (r_cols_of_b),
        .o_active (seq_active),
        .o_a_addr (a_raddr),
        .o_b_addr (b_raddr),
        .o_tag    (tag)
    );

    mme_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag),
        .i_a_data (a_rdata),
        .i_b_data (b_rdata),
        .o_busy   (mac_busy),
        .o_valid  (o_result_valid),
        .o_row    (o_out_row),
        .o_col    (o_out_col),
        .o_sum    (sum),
        .o_last   (o_last_element)
    );

    assign busy            = seq_active || mac_busy;
    assign o_product_value = signed'(sum);

endmodule

FILE: hdl/mme_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mme_seq.sv
// Address sequencer: walks i, j and k over the product and issues store reads.
// Depends on mme_pkg for the step tag type and the dimension widths.
module mme_seq #(
    parameter int MAX_DIM = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_go,
    input  logic [mme_pkg::DIM_W-1:0]            i_rows,
    input  logic [mme_pkg::DIM_W-1:0]            i_inner,
    input  logic [mme_pkg::DIM_W-1:0]            i_cols,
    output logic                                 o_active,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_a_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_b_addr,
    output mme_pkg::t_tag                        o_tag
);

    localparam int IW   = $clog2(MAX_DIM);
    localparam int CW   = $clog2(MAX_DIM + 1);
    localparam int AW   = $clog2(MAX_DIM * MAX_DIM);
    localparam int CMPW = (CW > mme_pkg::DIM_W) ? CW : mme_pkg::DIM_W;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_m, r_n, r_p, n_m, n_n, n_p;
    logic [IW-1:0]   r_i, r_j, r_k, n_i, n_j, n_k;
    logic            last_i, last_j, last_k;
    logic [CW-1:0]   go_m, go_p;

    // Dimensions above MAX_DIM are held at MAX_DIM.
    function automatic logic [CW-1:0] clamp_dim(input logic [mme_pkg::DIM_W-1:0] d);
        logic [CMPW-1:0] ext;
        logic [CMPW-1:0] lim;
        ext = CMPW'(d);
        lim = CMPW'(MAX_DIM);
        return (ext > lim) ? CW'(lim) : CW'(ext);
    endfunction

    assign go_m   = clamp_dim(i_rows);
    assign go_p   = clamp_dim(i_cols);
    assign last_i = (CW'(r_i) + CW'(1)) == r_m;
    assign last_j = (CW'(r_j) + CW'(1)) == r_p;
    assign last_k = ((CW'(r_k) + CW'(1)) == r_n) || (r_n == '0);

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_n     = r_n;
        n_p     = r_p;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_m = go_m;
                    n_n = clamp_dim(i_inner);
                    n_p = go_p;
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                    if ((go_m != '0) && (go_p != '0)) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (!last_k) begin
                    n_k = r_k + IW'(1);
                end else begin
                    n_k = '0;
                    if (!last_j) begin
                        n_j = r_j + IW'(1);
                    end else begin
                        n_j = '0;
                        if (!last_i) begin
                            n_i = r_i + IW'(1);
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_m <= n_m;
        r_n <= n_n;
        r_p <= n_p;
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
    end

    assign o_active = (r_state == S_RUN);
    assign o_a_addr = AW'(AW'(r_i) * AW'(MAX_DIM) + AW'(r_k));
    assign o_b_addr = AW'(AW'(r_k) * AW'(MAX_DIM) + AW'(r_j));

    always_comb begin
        o_tag           = '0;
        o_tag.valid     = (r_state == S_RUN);
        o_tag.first     = (r_k == '0);
        o_tag.last_k    = last_k;
        o_tag.zero      = (r_n == '0);
        o_tag.last_elem = last_i && last_j;
        o_tag.row       = mme_pkg::IDX_W'(r_i);
        o_tag.col       = mme_pkg::IDX_W'(r_j);
    end

endmodule

FILE: hdl/mme_mac.sv
// Multiply-accumulate datapath: product register, accumulator and result register.
// Depends on mme_pkg for the step tag type and the sum width.
module mme_mac #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mme_pkg::t_tag                  i_tag,
    input  logic [ELEM_WIDTH-1:0]          i_a_data,
    input  logic [ELEM_WIDTH-1:0]          i_b_data,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [mme_pkg::IDX_W-1:0]      o_row,
    output logic [mme_pkg::IDX_W-1:0]      o_col,
    output logic [mme_pkg::SUM_W-1:0]      o_sum,
    output logic                           o_last
);

    localparam int PW = 2 * ELEM_WIDTH;
    localparam int EW = (PW > mme_pkg::SUM_W) ? PW : mme_pkg::SUM_W;

    mme_pkg::t_tag               r_tag1, r_tag2;
    logic signed [PW-1:0]        r_prod;
    logic signed [EW-1:0]        prod_ext;
    logic [mme_pkg::SUM_W-1:0]   term, n_sum;
    logic [mme_pkg::SUM_W-1:0]   r_acc;
    logic                        r_valid;
    logic [mme_pkg::IDX_W-1:0]   r_row, r_col;
    logic [mme_pkg::SUM_W-1:0]   r_sum;
    logic                        r_last;

    assign prod_ext = EW'(r_prod);
    assign term     = r_tag2.zero ? '0 : prod_ext[mme_pkg::SUM_W-1:0];
    assign n_sum    = (r_tag2.first ? '0 : r_acc) + term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_tag1  <= i_tag;
            r_tag2  <= r_tag1;
            r_valid <= r_tag2.valid && r_tag2.last_k;
        end
        // Read data lines up with the first tag stage.
        r_prod <= signed'(i_a_data) * signed'(i_b_data);
        if (r_tag2.valid) begin
            r_acc <= n_sum;
        end
        if (r_tag2.valid && r_tag2.last_k) begin
            r_row  <= r_tag2.row;
            r_col  <= r_tag2.col;
            r_sum  <= n_sum;
            r_last <= r_tag2.last_elem;
        end
    end

    assign o_busy  = r_tag1.valid || r_tag2.valid;
    assign o_valid = r_valid;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_sum   = r_sum;
    assign o_last  = r_last;

endmodule

FILE: sim/matrix_multiply_engine_test.sv
// Self-checking testbench of matrix_multiply_engine: element loads, products, dimension writes.
// Depends on mme_pkg and the engine RTL; carries its own model of the product for checking.
`timescale 1ns / 100ps

module matrix_multiply_engine_test;

    // The engine is built with its default sizes, so the model assumes the same.
    localparam int DIM_LIMIT   = 8;
    localparam int DIM_RESET   = 8;
    localparam int ELEM_W      = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 23;
    // Mode code that the engine must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [mme_pkg::IDX_W-1:0]    row;
        logic [mme_pkg::IDX_W-1:0]    col;
        logic signed [ELEM_W-1:0]     value;
    } t_item;

    typedef struct packed {
        logic [mme_pkg::IDX_W-1:0]        row;
        logic [mme_pkg::IDX_W-1:0]        col;
        logic signed [mme_pkg::SUM_W-1:0] sum;
        logic                             last;
    } t_product_beat;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [1:0]                        i_mode = mme_pkg::MODE_WRITE_A;
    logic [mme_pkg::IDX_W-1:0]         i_row_index = '0;
    logic [mme_pkg::IDX_W-1:0]         i_col_index = '0;
    logic signed [ELEM_W-1:0]          i_element_value = '0;
    logic                              i_cfg_we = 1'b0;
    mme_pkg::t_cfg_reg                 i_cfg_index = mme_pkg::REG_ROWS_OF_A;
    logic [mme_pkg::DIM_W-1:0]         i_cfg_data = '0;
    logic                              o_result_valid;
    logic [mme_pkg::IDX_W-1:0]         o_out_row;
    logic [mme_pkg::IDX_W-1:0]         o_out_col;
    logic signed [mme_pkg::SUM_W-1:0]  o_product_value;
    logic                              o_last_element;

    // Items waiting for the driver, and product beats the engine still owes us.
    t_item         pending_items[$];
    t_product_beat due_products[$];

    // Model copy of the engine state, updated at the edges that the engine sees.
    logic signed [ELEM_W-1:0]  a_model[DIM_LIMIT*DIM_LIMIT];
    logic signed [ELEM_W-1:0]  b_model[DIM_LIMIT*DIM_LIMIT];
    logic [mme_pkg::DIM_W-1:0] model_rows;
    logic [mme_pkg::DIM_W-1:0] model_inner;
    logic [mme_pkg::DIM_W-1:0] model_cols;

    // Stimulus-side view: which entries have been loaded and which dimensions are set.
    // Nothing may read an entry before it is loaded, so products top up the stores first.
    bit                       a_loaded[DIM_LIMIT*DIM_LIMIT];
    bit                       b_loaded[DIM_LIMIT*DIM_LIMIT];
    int unsigned              plan_rows = DIM_RESET;
    int unsigned              plan_inner = DIM_RESET;
    int unsigned              plan_cols = DIM_RESET;

    bit                       steady = 1'b0;
    logic                     beat_taken = 1'b0;
    t_item                    next_item;
    int unsigned              mismatch_count = 0;
    int unsigned              stall_cycles = 0;

    matrix_multiply_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_element_value(i_element_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_product_value(o_product_value),
        .o_last_element (o_last_element)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Register values above the store size act as the store size.
    function automatic int unsigned dim_clamp(input int unsigned v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : v;
    endfunction

    // Element values lean on the two extremes, since those stress the sum width.
    function automatic logic signed [ELEM_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(7);
        if (roll == 0)
            return {1'b1, {(ELEM_W-1){1'b0}}};
        else if (roll == 1)
            return {1'b0, {(ELEM_W-1){1'b1}}};
        return ELEM_W'($urandom);
    endfunction

    function automatic int unsigned pick_dim();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 0;
        else if (roll < 8)
            return $urandom_range(1, 4);
        return $urandom_range(5, 15);
    endfunction

    // Works out what one accepted item does to the model, queueing any product beats.
    task automatic apply_item(input t_item itm);
        int unsigned   m;
        int unsigned   n;
        int unsigned   p;
        longint        acc;
        t_product_beat beat;
        m = dim_clamp(model_rows);
        n = dim_clamp(model_inner);
        p = dim_clamp(model_cols);
        case (itm.mode)
            mme_pkg::MODE_WRITE_A: a_model[{itm.row, itm.col}] = itm.value;
            mme_pkg::MODE_WRITE_B: b_model[{itm.row, itm.col}] = itm.value;
            mme_pkg::MODE_COMPUTE: begin
                for (int i = 0; i < m; i++) begin
                    for (int j = 0; j < p; j++) begin
                        acc = 0;
                        for (int k = 0; k < n; k++)
                            acc += longint'(a_model[i*DIM_LIMIT + k])
                                 * longint'(b_model[k*DIM_LIMIT + j]);
                        beat.row  = mme_pkg::IDX_W'(i);
                        beat.col  = mme_pkg::IDX_W'(j);
                        beat.sum  = acc[mme_pkg::SUM_W-1:0];
                        beat.last = (i == m - 1) && (j == p - 1);
                        due_products.push_back(beat);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [1:0] mode, input logic [mme_pkg::IDX_W-1:0] row,
                              input logic [mme_pkg::IDX_W-1:0] col,
                              input logic signed [ELEM_W-1:0] value);
        t_item itm;
        itm.mode  = mode;
        itm.row   = row;
        itm.col   = col;
        itm.value = value;
        if (mode == mme_pkg::MODE_WRITE_A)
            a_loaded[{row, col}] = 1'b1;
        else if (mode == mme_pkg::MODE_WRITE_B)
            b_loaded[{row, col}] = 1'b1;
        pending_items.push_back(itm);
    endtask

    // Loads every entry that the product will read and has not been loaded yet,
    // then queues the product itself.
    task automatic issue_product();
        int unsigned m;
        int unsigned n;
        int unsigned p;
        m = dim_clamp(plan_rows);
        n = dim_clamp(plan_inner);
        p = dim_clamp(plan_cols);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++)
                if (!a_loaded[i*DIM_LIMIT + k])
                    queue_item(mme_pkg::MODE_WRITE_A, mme_pkg::IDX_W'(i),
                               mme_pkg::IDX_W'(k), pick_value());
        for (int k = 0; k < n; k++)
            for (int j = 0; j < p; j++)
                if (!b_loaded[k*DIM_LIMIT + j])
                    queue_item(mme_pkg::MODE_WRITE_B, mme_pkg::IDX_W'(k),
                               mme_pkg::IDX_W'(j), pick_value());
        queue_item(mme_pkg::MODE_COMPUTE, mme_pkg::IDX_W'($urandom), mme_pkg::IDX_W'($urandom),
                   ELEM_W'($urandom));
    endtask

    // Returns once every queued item has gone in and every owed beat has come out.
    // The check is made just after the falling edge, once the driver has settled.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_items.size() != 0 || start || busy || due_products.size() != 0);
    endtask

    // Dimensions are only changed with the engine idle. A short pause lets the last
    // element load and the pipeline drain before the registers move.
    task automatic program_dims(input int unsigned rows, input int unsigned inner,
                                input int unsigned cols);
        wait_idle();
        repeat (6) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mme_pkg::REG_ROWS_OF_A;
        i_cfg_data  <= mme_pkg::DIM_W'(rows);
        @(negedge i_clk);
        i_cfg_index <= mme_pkg::REG_INNER_SIZE;
        i_cfg_data  <= mme_pkg::DIM_W'(inner);
        @(negedge i_clk);
        i_cfg_index <= mme_pkg::REG_COLS_OF_B;
        i_cfg_data  <= mme_pkg::DIM_W'(cols);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        plan_rows  = rows;
        plan_inner = inner;
        plan_cols  = cols;
    endtask

    // Driver: presents one item at a time and holds it until the engine takes the beat.
    // Outside the steady stretch it idles on about a quarter of its chances.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_item = pending_items.pop_front();
                start           <= 1'b1;
                i_mode          <= next_item.mode;
                i_row_index     <= next_item.row;
                i_col_index     <= next_item.col;
                i_element_value <= next_item.value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each product beat against the oldest owed one, then follows
    // register writes and accepted items in the model. A beat that arrives on the
    // edge that accepts a new product still belongs to the previous one, so the
    // check comes first.
    always @(posedge i_clk) begin
        beat_taken <= i_rst_n && start && !busy;
        if (!i_rst_n) begin
            model_rows  = DIM_RESET;
            model_inner = DIM_RESET;
            model_cols  = DIM_RESET;
        end else begin
            if (o_result_valid) begin
                if (due_products.size() == 0) begin
                    $display("%0t: expected no beat, got row %0d col %0d sum %0d last %0b",
                             $time, o_out_row, o_out_col, o_product_value, o_last_element);
                    mismatch_count++;
                end else begin
                    if (o_out_row !== due_products[0].row) begin
                        $display("%0t: out_row expected %0d, got %0d", $time,
                                 due_products[0].row, o_out_row);
                        mismatch_count++;
                    end
                    if (o_out_col !== due_products[0].col) begin
                        $display("%0t: out_col expected %0d, got %0d", $time,
                                 due_products[0].col, o_out_col);
                        mismatch_count++;
                    end
                    if (o_product_value !== due_products[0].sum) begin
                        $display("%0t: product_value expected %0d, got %0d", $time,
                                 due_products[0].sum, o_product_value);
                        mismatch_count++;
                    end
                    if (o_last_element !== due_products[0].last) begin
                        $display("%0t: last_element expected %0b, got %0b", $time,
                                 due_products[0].last, o_last_element);
                        mismatch_count++;
                    end
                    void'(due_products.pop_front());
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mme_pkg::REG_ROWS_OF_A:  model_rows  = i_cfg_data;
                    mme_pkg::REG_INNER_SIZE: model_inner = i_cfg_data;
                    mme_pkg::REG_COLS_OF_B:  model_cols  = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                apply_item(t_item'{i_mode, i_row_index, i_col_index, i_element_value});
        end
    end

    // Watchdog: a run that stops moving beats in either direction has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned made;
        int unsigned roll;
        int unsigned m;
        int unsigned n;
        int unsigned p;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A 2x2x2 product built mostly from the extremes, with loads at the far
        // corner of both stores and an unused mode that must change nothing.
        program_dims(2, 2, 2);
        queue_item(mme_pkg::MODE_WRITE_A, 0, 0, 16'sh8000);
        queue_item(mme_pkg::MODE_WRITE_A, 0, 1, 16'sh8000);
        queue_item(mme_pkg::MODE_WRITE_A, 1, 0, 16'sh7fff);
        queue_item(mme_pkg::MODE_WRITE_A, 1, 1, 16'sh0000);
        queue_item(mme_pkg::MODE_WRITE_B, 0, 0, 16'sh8000);
        queue_item(mme_pkg::MODE_WRITE_B, 1, 0, 16'sh8000);
        queue_item(mme_pkg::MODE_WRITE_B, 0, 1, 16'sh7fff);
        queue_item(mme_pkg::MODE_WRITE_B, 1, 1, 16'shffff);
        queue_item(mme_pkg::MODE_WRITE_A, 7, 7, 16'sh7fff);
        queue_item(mme_pkg::MODE_WRITE_B, 7, 7, 16'sh8000);
        queue_item(MODE_UNUSED, 0, 0, 16'sh1234);
        issue_product();
        // No rows, then no columns: the product must give no beat at all.
        program_dims(0, 2, 2);
        issue_product();
        program_dims(2, 2, 0);
        issue_product();
        // No inner dimension: one full row of zero sums.
        program_dims(1, 0, 8);
        issue_product();

        // Random part, in phases of fixed dimensions. The first phases pin the
        // saturating, smallest, largest and thin shapes; the rest are drawn at random,
        // mostly small. Loads mostly target the live part of the stores so that
        // products keep seeing fresh data.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: program_dims(15, 15, 15);
                1: program_dims(1, 1, 1);
                2: program_dims(8, 8, 8);
                3: program_dims(8, 1, 8);
                default: program_dims(pick_dim(), pick_dim(), pick_dim());
            endcase
            steady = (phase == 4) || (phase == 5);
            m = dim_clamp(plan_rows);
            n = dim_clamp(plan_inner);
            p = dim_clamp(plan_cols);
            made = 0;
            while (made < 28) begin
                roll = $urandom_range(99);
                if (roll < 3) begin
                    queue_item(MODE_UNUSED, mme_pkg::IDX_W'($urandom),
                               mme_pkg::IDX_W'($urandom), pick_value());
                end else begin
                    made++;
                    if (roll < 14)
                        issue_product();
                    else if (roll < 84 && m != 0 && n != 0 && p != 0) begin
                        if ($urandom_range(1))
                            queue_item(mme_pkg::MODE_WRITE_A,
                                       mme_pkg::IDX_W'($urandom_range(m - 1)),
                                       mme_pkg::IDX_W'($urandom_range(n - 1)), pick_value());
                        else
                            queue_item(mme_pkg::MODE_WRITE_B,
                                       mme_pkg::IDX_W'($urandom_range(n - 1)),
                                       mme_pkg::IDX_W'($urandom_range(p - 1)), pick_value());
                    end else begin
                        queue_item($urandom_range(1) ? mme_pkg::MODE_WRITE_B
                                                     : mme_pkg::MODE_WRITE_A,
                                   mme_pkg::IDX_W'($urandom), mme_pkg::IDX_W'($urandom),
                                   pick_value());
                    end
                end
            end
            issue_product();
        end
        steady = 1'b0;

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
